// ===== rtl/core/char_lcd_nibble_writer_defines.svh =====
// Assertion macros shared by the checker files of the LCD nibble writer.
// Depends on nothing; each user provides clk and rst_n in its scope.
`ifndef CHAR_LCD_NIBBLE_WRITER_DEFINES_SVH
`define CHAR_LCD_NIBBLE_WRITER_DEFINES_SVH

// Check a property at every edge outside reset.
`define CLNW_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check a property at every edge, reset included.
`define CLNW_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ===== rtl/core/clnw_pkg.sv =====
// Types, constants and helper functions of the LCD nibble writer.
// Depends on nothing; every other file of the block but the macro header uses it.
`default_nettype none

package clnw_pkg;

    localparam int LINE_CHARS = 16;
    // Cursor must hold both 2*LINE_CHARS-1 and a move to row 1, column 15
    localparam int POS_COUNT  = (2 * LINE_CHARS > LINE_CHARS + 16) ?
                                (2 * LINE_CHARS) : (LINE_CHARS + 16);
    localparam int CUR_W      = $clog2(POS_COUNT);

    localparam int Q_AW        = 2;
    localparam int QUEUE_DEPTH = 2 ** Q_AW;

    typedef logic [CUR_W-1:0] pos_t;
    typedef logic [CUR_W:0]   pos_ext_t;

    // Request codes
    localparam logic [2:0] CMD_DATA   = 3'd0;
    localparam logic [2:0] CMD_BYTE   = 3'd1;
    localparam logic [2:0] CMD_MOVE   = 3'd2;
    localparam logic [2:0] CMD_CLEAR  = 3'd3;
    localparam logic [2:0] CMD_NUMBER = 3'd4;
    localparam logic [2:0] CMD_INIT   = 3'd5;

    // Display bytes
    localparam logic [7:0] LCD_LINE2  = 8'hC0;
    localparam logic [7:0] LCD_HOME   = 8'h80;
    localparam logic [7:0] LCD_ROW2   = 8'h40;
    localparam logic [7:0] LCD_CLEAR  = 8'h01;
    localparam logic [7:0] ASCII_ZERO = 8'h30;

    localparam logic [13:0] NUMBER_MAX = 14'd9999;
    localparam logic [3:0]  INIT_LAST  = 4'd11;

    typedef enum logic [1:0] {
        JOB_DATA,
        JOB_CMD,
        JOB_SETPOS,
        JOB_INIT
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] code;
        pos_t       pos;
        logic       last;
    } job_t;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  data_byte;
        logic        row;
        logic [3:0]  column;
        logic [13:0] number;
    } in_item_t;

    typedef struct packed {
        logic [3:0] nibble;
        logic       rs;
        logic       last;
    } out_item_t;

    // Power-on sequence: 3,3,3,2 then 0x28, 0x08, 0x01, 0x0F by nibbles
    function automatic logic [3:0] init_nibble(input logic [3:0] step);
        logic [3:0] nib;
        unique case (step)
            4'd0:    nib = 4'h3;
            4'd1:    nib = 4'h3;
            4'd2:    nib = 4'h3;
            4'd3:    nib = 4'h2;
            4'd4:    nib = 4'h2;
            4'd5:    nib = 4'h8;
            4'd6:    nib = 4'h0;
            4'd7:    nib = 4'h8;
            4'd8:    nib = 4'h0;
            4'd9:    nib = 4'h1;
            4'd10:   nib = 4'h0;
            4'd11:   nib = 4'hF;
            default: nib = 4'h0;
        endcase
        return nib;
    endfunction

    // Decimal weight of digit slot, most significant first
    function automatic logic [13:0] dec_weight(input logic [1:0] idx);
        logic [13:0] w;
        unique case (idx)
            2'd0: w = 14'd1000;
            2'd1: w = 14'd100;
            2'd2: w = 14'd10;
            2'd3: w = 14'd1;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/clnw_front.sv =====
// Front end: accept requests, turn them into jobs, split numbers into digits.
// Depends on clnw_pkg.
`default_nettype none

module clnw_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire clnw_pkg::in_item_t item,
    input  wire logic               q_full,
    output logic                    job_push,
    output clnw_pkg::job_t          job
);

    logic        busy_reg, busy_next;
    logic [1:0]  idx_reg, idx_next;
    logic [13:0] rem_reg, rem_next;

    logic        accept;
    logic [13:0] number_sat;
    logic [13:0] dig_src;
    logic [1:0]  dig_idx;
    logic [13:0] weight;
    logic [3:0]  digit;
    logic [17:0] prod;
    logic [13:0] rem_after;
    clnw_pkg::pos_t pos_calc;
    logic [7:0]  pos8;
    logic [7:0]  move_code;

    assign full   = busy_reg || q_full;
    assign accept = push && !full;

    assign number_sat = (item.number > clnw_pkg::NUMBER_MAX) ? clnw_pkg::NUMBER_MAX
                                                             : item.number;
    assign dig_src = busy_reg ? rem_reg : number_sat;
    assign dig_idx = busy_reg ? idx_reg : 2'd0;
    assign weight  = clnw_pkg::dec_weight(dig_idx);

    // Digit is the count of multiples of the weight that fit
    always_comb
    begin
        digit = 4'd0;
        for (int k = 1; k <= 9; k++)
        begin
            if (18'(dig_src) >= 18'(k) * 18'(weight))
            begin
                digit = 4'(k);
            end
        end
    end

    assign prod      = 18'(digit) * 18'(weight);
    assign rem_after = dig_src - prod[13:0];

    assign pos_calc = clnw_pkg::pos_t'(item.row ? clnw_pkg::LINE_CHARS : 0)
                    + clnw_pkg::pos_t'(item.column);
    assign pos8     = 8'(pos_calc);

    always_comb
    begin
        if (pos8 < 8'(clnw_pkg::LINE_CHARS))
        begin
            move_code = clnw_pkg::LCD_HOME | pos8;
        end
        else if (pos8 < 8'(2 * clnw_pkg::LINE_CHARS))
        begin
            move_code = clnw_pkg::LCD_HOME
                      | (pos8 - 8'(clnw_pkg::LINE_CHARS) + clnw_pkg::LCD_ROW2);
        end
        else
        begin
            move_code = clnw_pkg::LCD_HOME
                      | (pos8 - 8'(2 * clnw_pkg::LINE_CHARS) + clnw_pkg::LCD_ROW2);
        end
    end

    // Job build
    always_comb
    begin
        job.kind = clnw_pkg::JOB_DATA;
        job.code = item.data_byte;
        job.pos  = '0;
        job.last = 1'b1;
        job_push = 1'b0;
        if (busy_reg)
        begin
            job.code = clnw_pkg::ASCII_ZERO | {4'd0, digit};
            job.last = (idx_reg == 2'd3);
            job_push = !q_full;
        end
        else
        begin
            unique case (item.cmd)
                clnw_pkg::CMD_DATA:
                begin
                    job_push = accept;
                end
                clnw_pkg::CMD_BYTE:
                begin
                    job.kind = clnw_pkg::JOB_CMD;
                    job_push = accept;
                end
                clnw_pkg::CMD_MOVE:
                begin
                    job.kind = clnw_pkg::JOB_SETPOS;
                    job.code = move_code;
                    job.pos  = pos_calc;
                    job_push = accept;
                end
                clnw_pkg::CMD_CLEAR:
                begin
                    job.kind = clnw_pkg::JOB_SETPOS;
                    job.code = clnw_pkg::LCD_CLEAR;
                    job_push = accept;
                end
                clnw_pkg::CMD_NUMBER:
                begin
                    job.code = clnw_pkg::ASCII_ZERO | {4'd0, digit};
                    job.last = 1'b0;
                    job_push = accept;
                end
                clnw_pkg::CMD_INIT:
                begin
                    job.kind = clnw_pkg::JOB_INIT;
                    job_push = accept;
                end
                default:
                begin
                    job_push = 1'b0;
                end
            endcase
        end
    end

    // Digit walk: advance one digit per queue slot
    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        rem_next  = rem_reg;
        if (busy_reg)
        begin
            if (!q_full)
            begin
                idx_next = idx_reg + 2'd1;
                rem_next = rem_after;
                if (idx_reg == 2'd3)
                begin
                    busy_next = 1'b0;
                end
            end
        end
        else if (accept && item.cmd == clnw_pkg::CMD_NUMBER)
        begin
            busy_next = 1'b1;
            idx_next  = 2'd1;
            rem_next  = rem_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/clnw_queue.sv =====
// Short job queue between front and back end, in flip-flops.
// Depends on clnw_pkg.
`default_nettype none

module clnw_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_en,
    input  wire clnw_pkg::job_t wr_data,
    output logic                full,
    input  wire logic           rd_en,
    output clnw_pkg::job_t      rd_data,
    output logic                empty
);

    clnw_pkg::job_t              slots_reg [clnw_pkg::QUEUE_DEPTH];
    logic [clnw_pkg::Q_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [clnw_pkg::Q_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [clnw_pkg::Q_AW:0]     count_reg, count_next;
    logic                        do_wr, do_rd;

    assign full    = count_reg[clnw_pkg::Q_AW];
    assign empty   = (count_reg == '0);
    assign rd_data = slots_reg[rd_ptr_reg];

    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/clnw_back.sv =====
// Back end: play out each job as nibbles, track the cursor, hold the output word.
// Depends on clnw_pkg.
`default_nettype none

module clnw_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire clnw_pkg::job_t job,
    input  wire logic           job_valid,
    output logic                job_pop,
    output clnw_pkg::out_item_t result,
    output logic                empty,
    input  wire logic           pop
);

    clnw_pkg::pos_t      cursor_reg, cursor_next;
    logic [3:0]          step_reg, step_next;
    logic                out_valid_reg, out_valid_next;
    clnw_pkg::out_item_t out_reg, out_next;

    logic                emit;
    logic                pre, post;
    clnw_pkg::pos_ext_t  cur_inc;
    logic [3:0]          slot;
    logic [3:0]          n_last;
    logic                is_final;
    logic [3:0]          nib;
    logic                rs;

    assign emit = job_valid && (!out_valid_reg || pop);

    // Line-two jump before the byte, home after the byte that wraps
    assign pre     = (cursor_reg == clnw_pkg::pos_t'(clnw_pkg::LINE_CHARS));
    assign cur_inc = clnw_pkg::pos_ext_t'(cursor_reg) + 1'b1;
    assign post    = (cur_inc >= clnw_pkg::pos_ext_t'(2 * clnw_pkg::LINE_CHARS));

    always_comb
    begin
        slot   = step_reg;
        n_last = 4'd1;
        nib    = 4'h0;
        rs     = 1'b0;
        unique case (job.kind)
            clnw_pkg::JOB_DATA:
            begin
                slot   = pre ? step_reg : step_reg + 4'd2;
                n_last = 4'd1 + (pre ? 4'd2 : 4'd0) + (post ? 4'd2 : 4'd0);
                case (slot)
                    4'd0:    nib = clnw_pkg::LCD_LINE2[7:4];
                    4'd1:    nib = clnw_pkg::LCD_LINE2[3:0];
                    4'd2:    nib = job.code[7:4];
                    4'd3:    nib = job.code[3:0];
                    4'd4:    nib = clnw_pkg::LCD_HOME[7:4];
                    4'd5:    nib = clnw_pkg::LCD_HOME[3:0];
                    default: nib = 4'h0;
                endcase
                rs = (slot == 4'd2) || (slot == 4'd3);
            end
            clnw_pkg::JOB_CMD, clnw_pkg::JOB_SETPOS:
            begin
                nib = step_reg[0] ? job.code[3:0] : job.code[7:4];
            end
            clnw_pkg::JOB_INIT:
            begin
                n_last = clnw_pkg::INIT_LAST;
                nib    = clnw_pkg::init_nibble(step_reg);
            end
        endcase
    end

    assign is_final = (step_reg == n_last);
    assign job_pop  = emit && is_final;

    always_comb
    begin
        step_next      = step_reg;
        cursor_next    = cursor_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !pop;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_next.nibble = nib;
            out_next.rs     = rs;
            out_next.last   = is_final && job.last;
            step_next       = is_final ? 4'd0 : step_reg + 4'd1;
            if (is_final)
            begin
                unique case (job.kind)
                    clnw_pkg::JOB_DATA:   cursor_next = post ? '0 : cur_inc[clnw_pkg::CUR_W-1:0];
                    clnw_pkg::JOB_CMD:    cursor_next = cursor_reg;
                    clnw_pkg::JOB_SETPOS: cursor_next = job.pos;
                    clnw_pkg::JOB_INIT:   cursor_next = '0;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg    <= '0;
            step_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cursor_reg    <= cursor_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result = out_reg;
    assign empty  = !out_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/core/char_lcd_nibble_writer.sv =====
// Top level of the 4-bit character LCD writer: front end, job queue, back end.
// Depends on clnw_pkg, clnw_front, clnw_queue and clnw_back.
//
//   channel   direction  handshake          word
//   request   in         push / full        item   (cmd, data_byte, row, column, number)
//   nibble    out        empty / pop        result (nibble, rs, last)
//
// The back end sends one nibble per cycle while jobs wait and nibbles are popped.
// An item has 2 nibbles for a command, move or clear, 2 to 4 for a data byte,
// 8 to 10 for a number, 12 for initialize. A number keeps full high after
// acceptance while its other digits enter the queue, one digit per cycle unless
// the queue is full. With nothing in flight an accepted item is written into the
// job queue, and its first nibble then goes through the output register to the
// result port. Reset empties the queue and the output stage and zeroes the
// cursor; full and empty stall each side on its own through the four-entry job queue.
`default_nettype none

module char_lcd_nibble_writer (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire clnw_pkg::in_item_t item,
    output logic                    empty,
    input  wire logic               pop,
    output clnw_pkg::out_item_t     result
);

    // Jobs from the front end into the queue
    clnw_pkg::job_t fe_job;
    logic           fe_push;
    logic           q_full;

    // Queue head toward the back end
    clnw_pkg::job_t q_head;
    logic           q_empty;
    logic           be_pop;

    // Accept requests, classify them, split numbers into digit jobs
    clnw_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .q_full   (q_full),
        .job_push (fe_push),
        .job      (fe_job)
    );

    // Decouple the two sides so either can stall alone
    clnw_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fe_push),
        .wr_data (fe_job),
        .full    (q_full),
        .rd_en   (be_pop),
        .rd_data (q_head),
        .empty   (q_empty)
    );

    // Play out jobs as nibbles; insert line and home commands on cursor wrap
    clnw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (q_head),
        .job_valid (!q_empty),
        .job_pop   (be_pop),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

`default_nettype wire

// ===== rtl/core/clnw_checker.sv =====
// Port-level checks for the LCD nibble writer, bound to the top level.
// Depends on clnw_pkg and char_lcd_nibble_writer_defines.svh.
`default_nettype none
`include "char_lcd_nibble_writer_defines.svh"

module clnw_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                push,
    input wire logic                full,
    input wire logic                empty,
    input wire logic                pop,
    input wire clnw_pkg::out_item_t result
);

    // Hold a waiting word until it is taken
    `CLNW_ASSERT(a_result_hold, !empty && !pop |=> !empty && $stable(result), "result word changed while stalled")

    // Reset leaves no word and room for a request
    `CLNW_ASSERT_ALWAYS(a_reset_idle, !rst_n |-> empty && !full, "not idle during reset")

    // Full rises only after a request was taken
    `CLNW_ASSERT(a_full_cause, $rose(full) |-> $past(push && !full), "full rose without an accepted request")

endmodule

bind char_lcd_nibble_writer clnw_checker u_clnw_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

`default_nettype wire
